// File: rtl/keypad_scan_debounce_edge_defines.svh
// Assertion macros shared by the keypad scanner modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef KEYPAD_SCAN_DEBOUNCE_EDGE_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_EDGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define KPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/kpsd_pkg.sv
// Types, constants and the key encoder for the keypad scanner.
// Depends on nothing; imported by every module of the block.
package kpsd_pkg;

    localparam int COL_W     = 4;
    localparam int ROW_W     = 2;
    localparam int MAP_W     = 16;
    localparam int CODE_W    = 7;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLICK  = 2'd1;

    localparam logic [TICK_W-1:0] SETTLE_RESET = 16'd50;
    localparam logic [TICK_W-1:0] FLICK_RESET  = 16'd1500;

    localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

    localparam logic [CODE_W-1:0] KEY_ASCII [MAP_W] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_FLICK  = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] flick_ticks;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]  row_drive;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
        logic [MAP_W-1:0]  new_key_map;
    } t_result;

    // Row 3 column 0 wins, then along row 3, then rows 2, 1 and 0.
    function automatic logic [CODE_W-1:0] f_pick_code(input logic [MAP_W-1:0] map);
        logic [CODE_W-1:0] code;
        code = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 3; c >= 0; c--) begin
                if (map[r*4 + c]) begin
                    code = KEY_ASCII[r*4 + c];
                end
            end
        end
        return code;
    endfunction

endpackage

// File: rtl/kpsd_cfg_regs.sv
// Configuration registers for settle and flick times.
// Depends on kpsd_pkg.
module kpsd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kpsd_pkg::TICK_W-1:0]    i_cfg_data,
    output kpsd_pkg::t_cfg                 o_cfg
);
    import kpsd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks <= SETTLE_RESET;
            r_cfg.flick_ticks  <= FLICK_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SETTLE) begin
                r_cfg.settle_ticks <= i_cfg_data;
            end else if (i_cfg_index == CFG_FLICK) begin
                r_cfg.flick_ticks <= i_cfg_data;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/kpsd_scan_seq.sv
// Row sequencer, scan maps, debounce and new-press encoder.
// Depends on kpsd_pkg and the assertion macro header.
`include "keypad_scan_debounce_edge_defines.svh"

module kpsd_scan_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [kpsd_pkg::COL_W-1:0] i_cols,
    input  kpsd_pkg::t_cfg             i_cfg,
    output kpsd_pkg::t_result          o_result
);
    import kpsd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [TICK_W-1:0]  r_wait, n_wait;
    logic [MAP_W-1:0]   r_first, n_first;
    logic [MAP_W-1:0]   r_second, n_second;
    logic [MAP_W-1:0]   r_prev, n_prev;
    logic [MAP_W-1:0]   deb_map;
    t_result            res;

    always_comb begin
        n_phase  = r_phase;
        n_row    = r_row;
        n_wait   = r_wait;
        n_first  = r_first;
        n_second = r_second;
        n_prev   = r_prev;
        deb_map  = '0;
        res      = '0;
        unique case (r_phase)
            PH_FLICK: begin
                if (r_wait >= i_cfg.flick_ticks) begin
                    n_phase = PH_SECOND;
                    n_row   = '0;
                    n_wait  = '0;
                end else begin
                    n_wait = r_wait + 16'd1;
                end
            end
            default: begin
                if (r_phase != PH_SECOND) begin
                    n_phase = PH_FIRST;
                end
                res.row_drive = 4'(4'd1 << r_row);
                if (r_wait >= i_cfg.settle_ticks) begin
                    n_wait = '0;
                    if (r_phase == PH_SECOND) begin
                        n_second[r_row*4 +: 4] = i_cols;
                    end else begin
                        n_first[r_row*4 +: 4] = i_cols;
                    end
                    if (r_row == LAST_ROW) begin
                        n_row = '0;
                        if (r_phase == PH_SECOND) begin
                            deb_map         = r_first & n_second;
                            res.new_key_map = deb_map & ~r_prev;
                            res.key_valid   = (res.new_key_map != '0);
                            res.key_code    = f_pick_code(res.new_key_map);
                            n_prev          = deb_map;
                            n_phase         = PH_FIRST;
                        end else begin
                            n_phase = PH_FLICK;
                        end
                    end else begin
                        n_row = r_row + 2'd1;
                    end
                end else begin
                    n_wait = r_wait + 16'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_row    <= '0;
            r_wait   <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_prev   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_row    <= n_row;
            r_wait   <= n_wait;
            r_first  <= n_first;
            r_second <= n_second;
            r_prev   <= n_prev;
        end
    end

    assign o_result = res;

    `KPSD_ASSERT_IMPLY(a_code_with_valid, i_clk, i_rst_n,
        res.key_valid, (res.key_code != '0) && (res.new_key_map != '0))
    `KPSD_ASSERT_NEXT(a_report_restarts, i_clk, i_rst_n,
        i_step && res.key_valid, (r_phase == PH_FIRST) && (r_row == '0))
    `KPSD_ASSERT_NEXT(a_flick_to_second, i_clk, i_rst_n,
        i_step && (r_phase == PH_FLICK) && (r_wait >= i_cfg.flick_ticks),
        (r_phase == PH_SECOND) && (r_wait == '0))

endmodule

// File: rtl/kpsd_out_stage.sv
// Output register between the sequencer and the result channel.
// Depends on kpsd_pkg.
module kpsd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    output logic              o_load_ready,
    input  kpsd_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output kpsd_pkg::t_result o_result
);
    import kpsd_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    load;

    assign o_load_ready = !r_valid || i_ready;
    assign load         = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/keypad_scan_debounce_edge.sv
// Top level of the 4x4 keypad scanner with debounce and new-press report.
// Depends on kpsd_pkg, kpsd_cfg_regs, kpsd_scan_seq and kpsd_out_stage.
//
// Each transaction on the s_axis channel is one time tick carrying the four
// column lines. Every tick yields exactly one transaction on m_axis with the
// row drive for that tick, and on the tick that ends the second scan the
// debounced new-press map and the ASCII code of the top-priority new key.
// The register channel writes settle_ticks (index 0) and flick_ticks
// (index 1); it is always ready and other indexes are ignored.
// An accepted tick's result is registered and appears on m_axis in the cycle after it is accepted.
// Throughput is one tick per cycle while the receiver is ready, set by the single
// output register that holds the result; a new tick is taken in the same cycle
// the held result drains.
// When the receiver stalls, the held result stays and s_axis_tready drops
// until it is taken.
// Reset clears the scan state and maps, empties the output register and
// loads settle_ticks with 50 and flick_ticks with 1500.
module keypad_scan_debounce_edge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [3:0] column_bits, [7:4] zero
    input  logic [7:0]                     s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] row_drive, [10:4] key_code, [26:11] new_key_map, [31:27] zero
    output logic [31:0]                    m_axis_tdata,
    // [0] key_valid
    output logic [0:0]                     m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kpsd_pkg::TICK_W-1:0]    i_cfg_data
);
    import kpsd_pkg::*;

    t_cfg    cfg;
    t_result seq_result;
    t_result out_result;
    logic    step;

    assign o_cfg_ready = 1'b1;
    assign step        = s_axis_tvalid && s_axis_tready;

    kpsd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kpsd_scan_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cols   (s_axis_tdata[COL_W-1:0]),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    kpsd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (s_axis_tvalid),
        .o_load_ready (s_axis_tready),
        .i_result     (seq_result),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (out_result)
    );

    assign m_axis_tdata = {5'd0, out_result.new_key_map, out_result.key_code,
                           out_result.row_drive};
    assign m_axis_tuser = out_result.key_valid;

endmodule

// File: verif/tb_keypad_scan_debounce_edge.sv
// Self-checking testbench for keypad_scan_debounce_edge: a keypad model answers the driven rows,
// and a scoreboard class predicts every result and checks it field by field.
// Depends on kpsd_pkg and the keypad_scan_debounce_edge RTL.
module tb_keypad_scan_debounce_edge;
    import kpsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    class keypad_scoreboard;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] flick_ticks;
        t_phase            phase;
        logic [ROW_W-1:0]  row;
        logic [TICK_W-1:0] wait_cnt;
        logic [MAP_W-1:0]  first_map;
        logic [MAP_W-1:0]  second_map;
        logic [MAP_W-1:0]  held_map;
        t_result           pending_reports[$];
        int                errors;

        function new();
            settle_ticks = SETTLE_RESET;
            flick_ticks  = FLICK_RESET;
            phase        = PH_FIRST;
            row          = '0;
            wait_cnt     = '0;
            first_map    = '0;
            second_map   = '0;
            held_map     = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] value);
            if (idx == CFG_SETTLE) begin
                settle_ticks = value;
            end else if (idx == CFG_FLICK) begin
                flick_ticks = value;
            end
        endfunction

        function logic [CODE_W-1:0] top_key(logic [MAP_W-1:0] fresh);
            string legend;
            legend = "123A456B789C*0#D";
            for (int r = 3; r >= 0; r--) begin
                for (int c = 0; c < 4; c++) begin
                    if (fresh[r*4 + c]) begin
                        return CODE_W'(legend.getc(r*4 + c));
                    end
                end
            end
            return '0;
        endfunction

        function void take_tick(logic [COL_W-1:0] cols);
            t_result          res;
            logic [MAP_W-1:0] stable;
            res = '0;
            if (phase == PH_FLICK) begin
                if (wait_cnt >= flick_ticks) begin
                    phase    = PH_SECOND;
                    row      = '0;
                    wait_cnt = '0;
                end else begin
                    wait_cnt++;
                end
            end else begin
                res.row_drive = 4'b0001 << row;
                if (wait_cnt >= settle_ticks) begin
                    wait_cnt = '0;
                    if (phase == PH_SECOND) begin
                        second_map[row*4 +: 4] = cols;
                    end else begin
                        first_map[row*4 +: 4] = cols;
                    end
                    if (row == LAST_ROW) begin
                        row = '0;
                        if (phase == PH_SECOND) begin
                            stable          = first_map & second_map;
                            res.new_key_map = stable & ~held_map;
                            res.key_valid   = |res.new_key_map;
                            res.key_code    = top_key(res.new_key_map);
                            held_map        = stable;
                            phase           = PH_FIRST;
                        end else begin
                            phase = PH_FLICK;
                        end
                    end else begin
                        row++;
                    end
                end else begin
                    wait_cnt++;
                end
            end
            pending_reports.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task match_report(t_result seen);
            t_result want;
            if (pending_reports.size() == 0) begin
                report("result arrived with nothing expected");
            end else begin
                want = pending_reports.pop_front();
                if (seen.row_drive !== want.row_drive) begin
                    report($sformatf("row_drive %h, expected %h", seen.row_drive,
                                     want.row_drive));
                end
                if (seen.key_valid !== want.key_valid) begin
                    report($sformatf("key_valid %b, expected %b", seen.key_valid,
                                     want.key_valid));
                end
                if (seen.key_code !== want.key_code) begin
                    report($sformatf("key_code %h, expected %h", seen.key_code,
                                     want.key_code));
                end
                if (seen.new_key_map !== want.new_key_map) begin
                    report($sformatf("new_key_map %h, expected %h", seen.new_key_map,
                                     want.new_key_map));
                end
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [TICK_W-1:0]    i_cfg_data    = '0;

    keypad_scoreboard sb = new();
    t_result          seen;
    logic [MAP_W-1:0] pad_keys = '0;
    int               send_gap_pct = 0;
    int               stall_pct = 0;
    int               cycles = 0;

    keypad_scan_debounce_edge dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.row_drive   = m_axis_tdata[3:0];
            seen.key_code    = m_axis_tdata[10:4];
            seen.new_key_map = m_axis_tdata[26:11];
            seen.key_valid   = m_axis_tuser[0];
            sb.match_report(seen);
        end
    end

    task automatic send_tick(input logic [COL_W-1:0] cols);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, cols};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_tick(cols);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
    endtask

    // The keypad answers the row that the next transaction will find driven.
    function automatic logic [COL_W-1:0] pad_columns();
        if (sb.phase == PH_FLICK) begin
            return '0;
        end
        return pad_keys[sb.row*4 +: 4];
    endfunction

    task automatic hold_pad(input logic [MAP_W-1:0] keys, input int ticks);
        pad_keys = keys;
        repeat (ticks) send_tick(pad_columns());
    endtask

    // Keys are pressed and released now and then, and contacts bounce.
    task automatic run_keypad(input int ticks);
        logic [COL_W-1:0] cols;
        int               k;
        for (int n = 0; n < ticks; n++) begin
            if ($urandom_range(99) < 4) begin
                k = $urandom_range(MAP_W - 1);
                pad_keys[k] = ~pad_keys[k];
            end
            if ($urandom_range(199) == 0) begin
                pad_keys = '0;
            end
            cols = pad_columns();
            if ($urandom_range(99) < 12) begin
                cols = COL_W'($urandom_range(15));
            end
            send_tick(cols);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: row 0 is held for 51 ticks, then the settle wait is cut short.
        pad_keys = 16'($urandom);
        run_keypad(55);
        write_reg(CFG_SETTLE, 16'd0);
        write_reg(CFG_FLICK, 16'd0);

        hold_pad(16'hFFFF, 6);
        hold_pad(16'h0000, 6);
        hold_pad(16'h8421, 6);
        hold_pad(16'h1248, 6);

        // Longest waits, each lowered while the block is inside it.
        write_reg(CFG_FLICK, 16'hFFFF);
        write_reg(CFG_SETTLE, 16'd1);
        while (sb.phase != PH_FLICK) run_keypad(1);
        run_keypad(30);
        write_reg(CFG_FLICK, 16'd2);
        run_keypad(1);
        write_reg(CFG_SETTLE, 16'hFFFF);
        run_keypad(40);
        write_reg(CFG_SETTLE, 16'd0);
        write_reg(CFG_SPARE_2, 16'($urandom));
        write_reg(CFG_SPARE_3, 16'($urandom));
        run_keypad(20);

        for (int mode = 0; mode < 4; mode++) begin
            send_gap_pct = (mode == 1) ? 70 : (mode == 3) ? 17 : 0;
            stall_pct    = (mode == 2) ? 70 : (mode == 3) ? 17 : 0;
            for (int seg = 0; seg < 2; seg++) begin
                write_reg(CFG_SETTLE, 16'($urandom_range(3)));
                write_reg(CFG_FLICK, 16'($urandom_range(7)));
                run_keypad(100);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/kpsd_pkg.sv
rtl/kpsd_cfg_regs.sv
rtl/kpsd_scan_seq.sv
rtl/kpsd_out_stage.sv
rtl/keypad_scan_debounce_edge.sv
verif/tb_keypad_scan_debounce_edge.sv
